// ----- hdl/ptl_pkg.sv -----
// shared types, constants and helpers for the primitive-to-triangle-list block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ptl_pkg;

	// default parameter values
	localparam int unsigned MAX_BATCH_DEF  = 32'd65536;
	localparam int unsigned INDEX_BITS_DEF = 32'd32;

	// fixed field widths
	localparam int unsigned OUT_INDEX_W = 32;
	localparam int unsigned MODE_W      = 3;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 3;
	localparam int unsigned STEP_W      = 3;

	// job queue depth between front and back
	localparam int unsigned JOB_FIFO_DEPTH = 2;

	// primitive codes
	localparam logic [MODE_W-1:0] MODE_FAN        = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUADS      = 3'd6;
	localparam logic [MODE_W-1:0] MODE_QUAD_STRIP = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIMITIVE_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQUENTIAL_MODE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_TOO_FEW     = 3'd1,
		ST_BAD_MULT    = 3'd2,
		ST_UNSUPPORTED = 3'd3,
		ST_TOO_LONG    = 3'd4
	} status_t;

	// what the back end has to emit for one vertex
	typedef enum logic [1:0] {
		JOB_NONE  = 2'd0,
		JOB_FAN   = 2'd1,
		JOB_QUAD  = 2'd2,
		JOB_STRIP = 2'd3
	} job_kind_t;

	typedef struct packed {
		job_kind_t              kind;
		logic                   last;
		status_t                status;
		logic [OUT_INDEX_W-1:0] first;
		logic [OUT_INDEX_W-1:0] a;
		logic [OUT_INDEX_W-1:0] b;
		logic [OUT_INDEX_W-1:0] c;
		logic [OUT_INDEX_W-1:0] v;
	} job_t;

	// index of the final result item of a job
	function automatic logic [STEP_W-1:0] job_last_step(input job_kind_t kind);
		logic [STEP_W-1:0] r;
		unique case (kind)
			JOB_FAN:             r = 3'd2;
			JOB_QUAD, JOB_STRIP: r = 3'd5;
			default:             r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ptl_front.sv -----
// front end: config registers, batch state and per-vertex classification
// depends on ptl_pkg; pushes one job per vertex that produces results
`timescale 1ns / 1ps
`default_nettype none

module ptl_front
	import ptl_pkg::*;
#(
	parameter int unsigned MAX_BATCH  = MAX_BATCH_DEF,
	parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [31:0]           vertex_index,
	input  wire logic                  last_vertex,
	output logic                       job_push,
	output job_t                       job,
	input  wire logic                  job_full
);

	localparam int unsigned POS_W = $clog2(64'(MAX_BATCH) + 64'd1);

	logic [MODE_W-1:0]     mode_q;
	logic                  seq_q;
	logic [INDEX_BITS-1:0] first_q;
	logic [INDEX_BITS-1:0] recent_q [3];
	logic [POS_W-1:0]      pos_q;
	logic                  ovf_q;

	logic                  accept;
	logic                  ovf_now;
	logic [POS_W-1:0]      pos_next;
	logic [INDEX_BITS-1:0] v;
	job_kind_t             kind;
	status_t               st;
	logic                  supported;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;
	assign ovf_now  = 64'(pos_q) >= 64'(MAX_BATCH);
	assign pos_next = ovf_now ? pos_q : pos_q + POS_W'(1);
	assign v        = seq_q ? INDEX_BITS'(64'(pos_q)) : vertex_index[INDEX_BITS-1:0];

	assign supported = (mode_q == MODE_FAN) || (mode_q == MODE_QUADS) ||
		(mode_q == MODE_QUAD_STRIP);

	always_comb begin
		kind = JOB_NONE;
		if (!ovf_now) begin
			if (mode_q == MODE_FAN && 64'(pos_q) >= 64'd2) begin
				kind = JOB_FAN;
			end else if (mode_q == MODE_QUADS && pos_q[1:0] == 2'b11) begin
				kind = JOB_QUAD;
			end else if (mode_q == MODE_QUAD_STRIP && 64'(pos_q) >= 64'd3 && pos_q[0]) begin
				kind = JOB_STRIP;
			end
		end
	end

	// end-of-batch status, by priority
	always_comb begin
		st = ST_OK;
		if (!supported) begin
			st = ST_UNSUPPORTED;
		end else if (ovf_q || ovf_now) begin
			st = ST_TOO_LONG;
		end else if (mode_q == MODE_FAN) begin
			st = (64'(pos_next) < 64'd3) ? ST_TOO_FEW : ST_OK;
		end else if (64'(pos_next) < 64'd4) begin
			st = ST_TOO_FEW;
		end else if (mode_q == MODE_QUADS) begin
			st = (pos_next[1:0] != 2'b00) ? ST_BAD_MULT : ST_OK;
		end else begin
			st = pos_next[0] ? ST_BAD_MULT : ST_OK;
		end
	end

	assign job_push = accept && (kind != JOB_NONE || last_vertex);

	always_comb begin
		job.kind   = kind;
		job.last   = last_vertex;
		job.status = last_vertex ? st : ST_OK;
		job.first  = OUT_INDEX_W'(first_q);
		job.a      = OUT_INDEX_W'(recent_q[2]);
		job.b      = OUT_INDEX_W'(recent_q[1]);
		job.c      = OUT_INDEX_W'(recent_q[0]);
		job.v      = OUT_INDEX_W'(v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			seq_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRIMITIVE_MODE:  mode_q <= cfg_data;
				REG_SEQUENTIAL_MODE: seq_q  <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= '0;
			recent_q[0] <= '0;
			recent_q[1] <= '0;
			recent_q[2] <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			if (last_vertex) begin
				first_q     <= '0;
				recent_q[0] <= '0;
				recent_q[1] <= '0;
				recent_q[2] <= '0;
				pos_q       <= '0;
				ovf_q       <= 1'b0;
			end else if (ovf_now) begin
				ovf_q <= 1'b1;
			end else begin
				if (pos_q == '0) begin
					first_q <= v;
				end
				recent_q[2] <= recent_q[1];
				recent_q[1] <= recent_q[0];
				recent_q[0] <= v;
				pos_q       <= pos_next;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ptl_job_fifo.sv -----
// short job queue decoupling the front end from the back end
// depends on ptl_pkg for job_t and the depth
`timescale 1ns / 1ps
`default_nettype none

module ptl_job_fifo
	import ptl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head
);

	localparam int unsigned PTR_W = $clog2(JOB_FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

	job_t             mem_q [JOB_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = count_q == CNT_W'(JOB_FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			if ((push && !full) && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!(push && !full) && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ptl_back.sv -----
// back end: unless out_ready low holds it, walks each job one corner per cycle into the output register
// depends on ptl_pkg for job_t and the sequencing helper
`timescale 1ns / 1ps
`default_nettype none

module ptl_back
	import ptl_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    job_valid,
	input  job_t                         job,
	output logic                         job_pop,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [OUT_INDEX_W-1:0]       out_index,
	output logic                         index_valid,
	output logic                         end_of_batch,
	output logic [STATUS_W-1:0]          status
);

	logic [STEP_W-1:0]      step_q;
	logic                   valid_q;
	logic [OUT_INDEX_W-1:0] index_q;
	logic                   ivalid_q;
	logic                   end_q;
	logic [STATUS_W-1:0]    status_q;

	logic                   load;
	logic                   last_step;
	logic [OUT_INDEX_W-1:0] corner;

	assign load      = job_valid && (!valid_q || out_ready);
	assign last_step = step_q == job_last_step(job.kind);
	assign job_pop   = load && last_step;

	always_comb begin
		corner = '0;
		unique case (job.kind)
			JOB_FAN: begin
				unique case (step_q)
					3'd0:    corner = job.first;
					3'd1:    corner = job.c;
					default: corner = job.v;
				endcase
			end
			JOB_QUAD: begin
				unique case (step_q)
					3'd0, 3'd3: corner = job.a;
					3'd1:       corner = job.b;
					3'd2, 3'd4: corner = job.c;
					default:    corner = job.v;
				endcase
			end
			JOB_STRIP: begin
				unique case (step_q)
					3'd0:       corner = job.a;
					3'd1, 3'd4: corner = job.b;
					3'd2, 3'd3: corner = job.c;
					default:    corner = job.v;
				endcase
			end
			default: corner = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q  <= last_step ? '0 : step_q + STEP_W'(1);
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			index_q  <= corner;
			ivalid_q <= job.kind != JOB_NONE;
			end_q    <= job.last && last_step;
			status_q <= (job.last && last_step) ? job.status : ST_OK;
		end
	end

	assign out_valid    = valid_q;
	assign out_index    = index_q;
	assign index_valid  = ivalid_q;
	assign end_of_batch = end_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ----- hdl/primitive_to_triangle_list.sv -----
// top level: fan / quad / quad-strip batches to a triangle-list index stream
// depends on ptl_pkg, ptl_front, ptl_job_fifo and ptl_back
//
//   channel  dir  handshake          payload
//   cfg      in   cfg_we             cfg_index (register), cfg_data
//   s_*      in   s_tvalid/s_tready  s_tdata vertex_index, s_tlast last_vertex
//   m_*      out  m_tvalid/m_tready  m_tdata out_index+status, m_tuser index_valid,
//                                    m_tlast end_of_batch
//
// a vertex is classified in the cycle it transfers and its job enters a two-entry
// queue; the back end emits one corner per cycle while m_tready allows, so a fan
// vertex yields 3 results, a completing quad or quad-strip vertex 6, a status-only end 1.
// the first result is registered in the job queue and then in the output register.
// s_tready drops only while the job queue is full; the output register holds
// a result under m_tready low while the front keeps taking vertices until the queue fills.
// arst_n clears config registers, batch state, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module primitive_to_triangle_list
	import ptl_pkg::*;
#(
	parameter int unsigned MAX_BATCH  = MAX_BATCH_DEF,
	parameter int unsigned INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// vertex stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,   // [31:0] vertex_index
	input  wire logic                  s_tlast,   // last_vertex
	// triangle-list stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [39:0]                m_tdata,   // [31:0] out_index, [34:32] status, [39:35] zero
	output logic                       m_tuser,   // [0] index_valid
	output logic                       m_tlast    // end_of_batch
);

	// jobs between classification and emission
	logic job_push;
	job_t job_in;
	logic job_full;
	logic job_pop;
	logic job_valid;
	job_t job_head;

	logic [OUT_INDEX_W-1:0] out_index;
	logic [STATUS_W-1:0]    status;

	// front: config registers, batch position, corner history
	ptl_front #(
		.MAX_BATCH  (MAX_BATCH),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.vertex_index (s_tdata),
		.last_vertex  (s_tlast),
		.job_push     (job_push),
		.job          (job_in),
		.job_full     (job_full)
	);

	// short queue so either side can stall on its own
	ptl_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_data  (job_in),
		.full       (job_full),
		.pop        (job_pop),
		.head_valid (job_valid),
		.head       (job_head)
	);

	// back: sequences corners of each job into the output register
	ptl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job_head),
		.job_pop      (job_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_index    (out_index),
		.index_valid  (m_tuser),
		.end_of_batch (m_tlast),
		.status       (status)
	);

	assign m_tdata = {5'b0, status, out_index};

	// a status-only item always closes a batch
	a_status_only_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("status-only result without end of batch");

	// a status-only item carries a zero index
	a_status_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("status-only result with nonzero index");

	// a nonzero status appears only on the final result of a batch
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:32] != 3'd0 |-> m_tlast)
		else $error("status reported before end of batch");

	// the front only stalls while the back end still has work queued
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> job_valid)
		else $error("input stalled with an empty job queue");

endmodule

`default_nettype wire
